@@ rtl/dett_pkg.sv @@
// Shared types, constants and codes of the delay event timer table.
package dett_pkg;

    localparam int unsigned SLOTS_DEF      = 8;
    localparam logic [7:0]  EMPTY_CODE_DEF = 8'h00;
    localparam int unsigned MAX_RESULTS    = 8;
    localparam int unsigned NREP_W         = $clog2(MAX_RESULTS + 1);

    localparam logic CMD_SET     = 1'b0;
    localparam logic CMD_TICK    = 1'b1;
    localparam logic KIND_SET    = 1'b0;
    localparam logic KIND_EXPIRY = 1'b1;
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [7:0]  event_code;
        logic [31:0] delay_ms;
        logic        overwrite;
        logic [31:0] now_ms;
    } t_in_item;

    typedef struct packed {
        logic       kind;
        logic       status;
        logic [2:0] slot_index;
        logic [7:0] expired_code;
        logic       last;
    } t_out_item;

    typedef struct packed {
        logic [7:0]  code;
        logic [31:0] remaining;
    } t_slot_word;

    typedef struct packed {
        logic [31:0] diff;
        logic        borrow;
        logic        zero;
    } t_sub_res;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TCHK,
        S_RD,
        S_EVAL,
        S_COMMIT,
        S_FLUSH
    } t_state;

endpackage

@@ rtl/delay_event_timer_table.sv @@
// Top level of the delay event timer table: slot store, sequencer and output register.
//
// Requests arrive on the input channel (i_in_valid, o_in_stall, i_in). A set
// request arms, re-arms or cancels one event type and always yields exactly
// one result. A tick request carries the current millisecond time; when more
// than 1 ms has passed it counts every armed slot down and, if reporting is
// enabled, yields one expiry report per slot that reached zero, at most eight.
// The final result of a request carries last = 1.
// The slots sit in a memory with one read port, so the sequencer visits one
// slot at a time (read, then evaluate and write back). A set ends with a
// commit after the scan; a tick that comes too soon ends straight after the
// elapsed-time check. One request is in work at a time.
// Results leave through an output register, so a stalled receiver only holds
// the sequencer when a further result is ready; the scan resumes once the
// register drains. The report_expiry register is written through the
// configuration channel, which is always ready. Synchronous reset empties
// every slot, clears the last tick time and turns reporting off.
module delay_event_timer_table
    import dett_pkg::*;
#(
    parameter int unsigned SLOTS      = SLOTS_DEF,
    parameter logic [7:0]  EMPTY_CODE = EMPTY_CODE_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic      i_cfg_data
);

    localparam int unsigned AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic          r_report;
    logic          r_out_vld;
    t_out_item     r_out;
    logic          w_out_free;
    logic          w_push;
    t_out_item     w_push_item;
    logic          w_rd_en;
    logic [AW-1:0] w_rd_addr;
    t_slot_word    w_rd_data;
    logic          w_wr_en;
    logic [AW-1:0] w_wr_addr;
    t_slot_word    w_wr_data;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_report <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_report <= i_cfg_data;
        end
    end

    // The output register is free when empty or when its result leaves now.
    assign w_out_free = !r_out_vld || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_push) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_out <= w_push_item;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

    dett_slot_mem #(
        .SLOTS      (SLOTS),
        .EMPTY_CODE (EMPTY_CODE)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data)
    );

    dett_seq #(
        .SLOTS      (SLOTS),
        .EMPTY_CODE (EMPTY_CODE)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .i_report    (r_report),
        .i_out_free  (w_out_free),
        .o_push      (w_push),
        .o_push_item (w_push_item),
        .o_rd_en     (w_rd_en),
        .o_rd_addr   (w_rd_addr),
        .i_rd_data   (w_rd_data),
        .o_wr_en     (w_wr_en),
        .o_wr_addr   (w_wr_addr),
        .o_wr_data   (w_wr_data)
    );

endmodule

@@ rtl/dett_sub_unit.sv @@
// Shared 32-bit subtractor with borrow and zero flags.
module dett_sub_unit
    import dett_pkg::*;
(
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output t_sub_res    o_res
);

    logic [32:0] w_full;

    assign w_full       = {1'b0, i_a} - {1'b0, i_b};
    assign o_res.diff   = w_full[31:0];
    assign o_res.borrow = w_full[32];
    assign o_res.zero   = (w_full[31:0] == 32'd0);

endmodule

@@ rtl/dett_slot_mem.sv @@
// Slot store: event type and remaining delay per slot, with per-slot valid bits.
module dett_slot_mem
    import dett_pkg::*;
#(
    parameter int unsigned SLOTS      = SLOTS_DEF,
    parameter logic [7:0]  EMPTY_CODE = EMPTY_CODE_DEF,
    localparam int unsigned AW        = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output t_slot_word    o_rd_data,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_slot_word    i_wr_data
);

    t_slot_word             r_mem [SLOTS];
    logic       [SLOTS-1:0] r_valid;
    t_slot_word             r_rd_data;
    logic                   r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data  <= r_mem[i_rd_addr];
            r_rd_valid <= r_valid[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    // A slot never written reads as its reset contents.
    assign o_rd_data = r_rd_valid ? r_rd_data : t_slot_word'{EMPTY_CODE, 32'd0};

endmodule

@@ rtl/dett_seq.sv @@
// Sequencer that scans the slots one at a time for set and tick requests.
module dett_seq
    import dett_pkg::*;
#(
    parameter int unsigned SLOTS      = SLOTS_DEF,
    parameter logic [7:0]  EMPTY_CODE = EMPTY_CODE_DEF,
    localparam int unsigned AW        = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  t_in_item      i_in,
    input  logic          i_report,
    input  logic          i_out_free,
    output logic          o_push,
    output t_out_item     o_push_item,
    output logic          o_rd_en,
    output logic [AW-1:0] o_rd_addr,
    input  t_slot_word    i_rd_data,
    output logic          o_wr_en,
    output logic [AW-1:0] o_wr_addr,
    output t_slot_word    o_wr_data
);

    t_state            r_state, n_state;
    t_in_item          r_req, n_req;
    logic [AW-1:0]     r_ptr, n_ptr;
    logic [31:0]       r_last_tick, n_last_tick;
    logic [31:0]       r_elapsed, n_elapsed;
    logic              r_match_f, n_match_f;
    logic [AW-1:0]     r_match_idx, n_match_idx;
    logic              r_empty_f, n_empty_f;
    logic [AW-1:0]     r_empty_idx, n_empty_idx;
    logic [NREP_W-1:0] r_nrep, n_nrep;
    logic              r_pend_vld, n_pend_vld;
    t_out_item         r_pend, n_pend;

    logic        w_accept;
    logic        w_scan_end;
    logic        w_go;
    logic        w_report;
    logic        w_rem_nz;
    logic        w_full;
    logic [31:0] w_sub_a;
    logic [31:0] w_sub_b;
    t_sub_res    w_sub;
    logic [AW-1:0] w_target;

    dett_sub_unit u_sub (
        .i_a   (w_sub_a),
        .i_b   (w_sub_b),
        .o_res (w_sub)
    );

    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_scan_end = (r_ptr == AW'(SLOTS - 1));
    assign w_rem_nz   = (i_rd_data.remaining != 32'd0);
    assign w_report   = (r_req.cmd == CMD_TICK) && w_rem_nz &&
                        (w_sub.borrow || w_sub.zero) && i_report &&
                        (r_nrep < NREP_W'(MAX_RESULTS));
    assign w_full     = !r_match_f && !r_empty_f;
    assign w_target   = r_match_f ? r_match_idx : r_empty_idx;

    // The subtractor serves the elapsed-time check and every countdown step.
    always_comb begin
        if (r_state == S_TCHK) begin
            w_sub_a = r_req.now_ms;
            w_sub_b = r_last_tick;
        end else begin
            w_sub_a = i_rd_data.remaining;
            w_sub_b = r_elapsed;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = (i_in.cmd == CMD_TICK) ? S_TCHK : S_RD;
                end
            end
            S_TCHK: begin
                n_state = (w_sub.diff[31:1] == '0) ? S_IDLE : S_RD;
            end
            S_RD: begin
                n_state = S_EVAL;
            end
            S_EVAL: begin
                if (w_go) begin
                    if (w_scan_end) begin
                        n_state = (r_req.cmd == CMD_SET) ? S_COMMIT : S_FLUSH;
                    end else begin
                        n_state = S_RD;
                    end
                end
            end
            S_COMMIT: begin
                n_state = S_FLUSH;
            end
            S_FLUSH: begin
                if (!r_pend_vld || i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Outputs toward the slot store and the output register.
    always_comb begin
        o_in_stall  = (r_state != S_IDLE);
        o_rd_en     = 1'b0;
        o_rd_addr   = r_ptr;
        o_wr_en     = 1'b0;
        o_wr_addr   = r_ptr;
        o_wr_data   = t_slot_word'{i_rd_data.code, w_sub.borrow ? 32'd0 : w_sub.diff};
        o_push      = 1'b0;
        o_push_item = r_pend;
        w_go        = 1'b1;
        case (r_state)
            S_RD: begin
                o_rd_en = 1'b1;
            end
            S_EVAL: begin
                if (w_report && r_pend_vld) begin
                    w_go   = i_out_free;
                    o_push = i_out_free;
                end
                o_wr_en = (r_req.cmd == CMD_TICK) && w_rem_nz && w_go;
            end
            S_COMMIT: begin
                o_wr_addr = w_target;
                o_wr_en   = !w_full &&
                            ((r_match_f ? r_req.overwrite : 1'b1) ||
                             (r_req.delay_ms == 32'd0));
                if (r_req.delay_ms == 32'd0) begin
                    o_wr_data = t_slot_word'{EMPTY_CODE, 32'd0};
                end else begin
                    o_wr_data = t_slot_word'{r_req.event_code, r_req.delay_ms};
                end
            end
            S_FLUSH: begin
                o_push           = r_pend_vld && i_out_free;
                o_push_item.last = 1'b1;
            end
            default: begin
                w_go = 1'b1;
            end
        endcase
    end

    // Datapath registers.
    always_comb begin
        n_req       = r_req;
        n_ptr       = r_ptr;
        n_last_tick = r_last_tick;
        n_elapsed   = r_elapsed;
        n_match_f   = r_match_f;
        n_match_idx = r_match_idx;
        n_empty_f   = r_empty_f;
        n_empty_idx = r_empty_idx;
        n_nrep      = r_nrep;
        n_pend_vld  = r_pend_vld;
        n_pend      = r_pend;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_req      = i_in;
                    n_ptr      = '0;
                    n_match_f  = 1'b0;
                    n_empty_f  = 1'b0;
                    n_nrep     = '0;
                    n_pend_vld = 1'b0;
                end
            end
            S_TCHK: begin
                n_elapsed = w_sub.diff;
                if (w_sub.diff[31:1] != '0) begin
                    n_last_tick = r_req.now_ms;
                end
            end
            S_EVAL: begin
                if (r_req.cmd == CMD_SET) begin
                    if (!r_match_f && (i_rd_data.code == r_req.event_code)) begin
                        n_match_f   = 1'b1;
                        n_match_idx = r_ptr;
                    end
                    if (!r_empty_f && (i_rd_data.code == EMPTY_CODE)) begin
                        n_empty_f   = 1'b1;
                        n_empty_idx = r_ptr;
                    end
                end else if (w_report && w_go) begin
                    n_pend_vld = 1'b1;
                    n_pend     = t_out_item'{KIND_EXPIRY, STATUS_OK, 3'(r_ptr),
                                             i_rd_data.code, 1'b0};
                    n_nrep     = r_nrep + NREP_W'(1);
                end
                if (w_go && !w_scan_end) begin
                    n_ptr = r_ptr + AW'(1);
                end
            end
            S_COMMIT: begin
                n_pend_vld = 1'b1;
                n_pend     = t_out_item'{KIND_SET, w_full ? STATUS_FULL : STATUS_OK,
                                         w_full ? 3'd0 : 3'(w_target), 8'd0, 1'b1};
            end
            S_FLUSH: begin
                if (i_out_free) begin
                    n_pend_vld = 1'b0;
                end
            end
            default: begin
                n_pend_vld = r_pend_vld;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_last_tick <= 32'd0;
            r_pend_vld  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_last_tick <= n_last_tick;
            r_pend_vld  <= n_pend_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req       <= n_req;
        r_ptr       <= n_ptr;
        r_elapsed   <= n_elapsed;
        r_match_f   <= n_match_f;
        r_match_idx <= n_match_idx;
        r_empty_f   <= n_empty_f;
        r_empty_idx <= n_empty_idx;
        r_nrep      <= n_nrep;
        r_pend      <= n_pend;
    end

endmodule

@@ tb/sv/dett_checker.sv @@
// Checker for the delay event timer table: watches all channels, predicts and compares.
`timescale 1ns / 1ps

module dett_checker
    import dett_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  t_in_item    i_in,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  t_out_item   i_out,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic        i_cfg_data,
    output int unsigned o_fail_count,
    output int unsigned o_outstanding
);

    localparam int unsigned NSLOT     = SLOTS_DEF;
    localparam int unsigned MAX_SHOWN = 10;

    logic [7:0]  slot_code [NSLOT];
    logic [31:0] slot_left [NSLOT];
    logic [31:0] tick_mark;
    logic        expiry_on;
    t_out_item   table_responses [$];
    int unsigned fail_total  = 0;
    int unsigned owed_total  = 0;

    assign o_fail_count  = fail_total;
    assign o_outstanding = owed_total;

    function automatic int first_slot_of(logic [7:0] code);
        for (int s = 0; s < NSLOT; s++) begin
            if (slot_code[s] == code) begin
                return s;
            end
        end
        return -1;
    endfunction

    // A set request always answers once: the slot it used, or table full.
    function automatic void arm_timer(t_in_item req);
        int        s;
        t_out_item r;
        r        = '0;
        r.kind   = KIND_SET;
        r.status = STATUS_OK;
        r.last   = 1'b1;
        s = first_slot_of(req.event_code);
        if (s < 0) begin
            s = first_slot_of(EMPTY_CODE_DEF);
            if (s < 0) begin
                r.status = STATUS_FULL;
                table_responses.push_back(r);
                return;
            end
            slot_code[s] = req.event_code;
            slot_left[s] = req.delay_ms;
        end else if (req.overwrite) begin
            slot_code[s] = req.event_code;
            slot_left[s] = req.delay_ms;
        end
        if (req.delay_ms == 32'd0) begin
            slot_code[s] = EMPTY_CODE_DEF;
            slot_left[s] = 32'd0;
        end
        r.slot_index = 3'(s);
        table_responses.push_back(r);
    endfunction

    function automatic void advance_clock(logic [31:0] now);
        logic [31:0]      span;
        logic [NSLOT-1:0] hit;
        int               total;
        int               seen;
        t_out_item        r;
        span = now - tick_mark;
        if (span <= 32'd1) begin
            return;
        end
        tick_mark = now;
        hit       = '0;
        total     = 0;
        for (int s = 0; s < NSLOT; s++) begin
            if (slot_left[s] != 32'd0) begin
                slot_left[s] = (span > slot_left[s]) ? 32'd0 : slot_left[s] - span;
                if (slot_left[s] == 32'd0 && expiry_on && total < MAX_RESULTS) begin
                    hit[s] = 1'b1;
                    total++;
                end
            end
        end
        seen = 0;
        for (int s = 0; s < NSLOT; s++) begin
            if (hit[s]) begin
                r              = '0;
                r.kind         = KIND_EXPIRY;
                r.status       = STATUS_OK;
                r.slot_index   = 3'(s);
                r.expired_code = slot_code[s];
                r.last         = (seen == total - 1);
                table_responses.push_back(r);
                seen++;
            end
        end
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            for (int s = 0; s < NSLOT; s++) begin
                slot_code[s] = EMPTY_CODE_DEF;
                slot_left[s] = 32'd0;
            end
            tick_mark = 32'd0;
            expiry_on = 1'b0;
            table_responses.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                expiry_on = i_cfg_data;
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_in.cmd == CMD_SET) begin
                    arm_timer(i_in);
                end else begin
                    advance_clock(i_in.now_ms);
                end
            end
            if (i_out_valid && !i_out_stall) begin
                if (table_responses.size() == 0) begin
                    fail_total++;
                    if (fail_total <= MAX_SHOWN) begin
                        $display("%0t: result with nothing owed: kind %0d status %0d slot %0d code %02h last %0d",
                                 $realtime, i_out.kind, i_out.status, i_out.slot_index,
                                 i_out.expired_code, i_out.last);
                    end
                end else begin
                    want = table_responses.pop_front();
                    if (i_out.kind !== want.kind || i_out.status !== want.status ||
                        i_out.slot_index !== want.slot_index ||
                        i_out.expired_code !== want.expired_code ||
                        i_out.last !== want.last) begin
                        fail_total++;
                        if (fail_total <= MAX_SHOWN) begin
                            $display("%0t: mismatch kind %0d/%0d status %0d/%0d slot %0d/%0d code %02h/%02h last %0d/%0d (exp/got)",
                                     $realtime, want.kind, i_out.kind, want.status, i_out.status,
                                     want.slot_index, i_out.slot_index, want.expired_code,
                                     i_out.expired_code, want.last, i_out.last);
                        end
                    end
                end
            end
        end
        owed_total = table_responses.size();
    end

endmodule

@@ tb/sv/tb_delay_event_timer_table.sv @@
// Testbench top for the delay event timer table: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

// The top drives three channels at the falling clock edge: set and tick
// requests on the input channel, the report_expiry register on the
// configuration channel, and the stall of the result channel. A checker
// module beside the block watches every handshake at the rising edge, keeps
// its own copy of the slot table and compares each result with its forecast.
// The top only produces stimulus and decides pass or fail from the checker's
// failure and outstanding counts and from a watchdog.
module tb_delay_event_timer_table;
    import dett_pkg::*;

    localparam int unsigned PHASES        = 4;
    localparam int unsigned PHASE_ITEMS   = 110;
    // report_expiry for each random phase, bit p belongs to phase p.
    localparam logic [3:0]  PHASE_REPORT  = 4'b1101;
    // Wait that lets a tick with no result finish its scan.
    localparam int unsigned SETTLE_CYCLES = 40;
    localparam int unsigned QUIET_LIMIT   = 3000;
    localparam int unsigned LONG_HOLD     = 400;
    localparam int unsigned CODE_MEMORY   = 24;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    t_in_item    in_req;
    logic        out_valid;
    logic        out_stall;
    t_out_item   out_rsp;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_data;
    int unsigned fail_count;
    int unsigned outstanding;

    // Current millisecond time as last sent, and codes that were armed
    // recently so that cancels usually hit a live slot.
    logic [31:0] clock_now;
    logic [7:0]  armed_codes [$];
    logic        squeeze_due;

    delay_event_timer_table i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_req),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_rsp),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    dett_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_in          (in_req),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_out         (out_rsp),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_data    (cfg_data),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Both sides draw a random wait before each item. Now and then a side enters
    // a calm run in which it never waits, so back-to-back traffic happens too.
    function automatic int unsigned draw_wait(ref int unsigned run_left, ref logic calm);
        if (run_left == 0) begin
            run_left = $urandom_range(10, 40);
            calm     = ($urandom_range(0, 3) == 0);
        end
        run_left--;
        return calm ? 0 : $urandom_range(0, 12);
    endfunction

    // Fields that a request kind ignores still carry random bits.
    function automatic t_in_item set_req(logic [7:0] code, logic [31:0] delay, logic ow);
        t_in_item it;
        it            = '0;
        it.cmd        = CMD_SET;
        it.event_code = code;
        it.delay_ms   = delay;
        it.overwrite  = ow;
        it.now_ms     = $urandom();
        return it;
    endfunction

    function automatic t_in_item tick_req(logic [31:0] now);
        t_in_item it;
        it            = '0;
        it.cmd        = CMD_TICK;
        it.event_code = 8'($urandom_range(0, 255));
        it.delay_ms   = $urandom();
        it.overwrite  = 1'($urandom_range(0, 1));
        it.now_ms     = now;
        return it;
    endfunction

    // Random traffic stays mostly within a handful of event codes so that
    // matches, re-arms, cancels and a full table all come up often. Delays
    // are mostly short next to the tick steps so that slots really expire.
    function automatic t_in_item random_req();
        t_in_item    it;
        int unsigned roll;
        logic [31:0] step;
        logic [7:0]  code;
        logic [31:0] delay;
        if ($urandom_range(0, 99) < 55) begin
            code = 8'($urandom_range(0, 255));
            roll = $urandom_range(0, 99);
            if (roll < 65) begin
                code = 8'($urandom_range(1, 10));
            end else if (roll < 72) begin
                code = EMPTY_CODE_DEF;
            end
            roll = $urandom_range(0, 99);
            if (roll < 12) begin
                delay = 32'd0;
                if (armed_codes.size() != 0) begin
                    code = armed_codes[$urandom_range(0, armed_codes.size() - 1)];
                end
            end else if (roll < 72) begin
                delay = $urandom_range(1, 40);
            end else if (roll < 87) begin
                delay = $urandom_range(41, 2000);
            end else begin
                delay = $urandom();
            end
            if (delay != 32'd0) begin
                armed_codes.push_back(code);
                if (armed_codes.size() > CODE_MEMORY) begin
                    void'(armed_codes.pop_front());
                end
            end
            it = set_req(code, delay, 1'($urandom_range(0, 1)));
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < 15) begin
                step = $urandom_range(0, 1);
            end else if (roll < 75) begin
                step = $urandom_range(2, 25);
            end else if (roll < 90) begin
                step = $urandom_range(26, 500);
            end else begin
                step = $urandom();
            end
            clock_now = clock_now + step;
            it = tick_req(clock_now);
        end
        return it;
    endfunction

    int unsigned send_run  = 0;
    logic        send_calm = 1'b0;

    // Present one request after a random gap and hold it until it is taken.
    // Valid only drops when a gap follows, so it is never lowered and raised
    // within the same step.
    task automatic offer(input t_in_item it);
        int unsigned gap;
        gap = draw_wait(send_run, send_calm);
        @(negedge clk);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_req   <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // The register is only written while the block is idle: no request
    // offered, every owed result delivered, and time for a silent tick to end.
    task automatic write_report(input logic enable);
        @(negedge clk);
        in_valid <= 1'b0;
        while (outstanding != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= enable;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Result side: a random stall before each result, and once a long
    // hold-off while the sender keeps pushing, so that the block backs up
    // and stalls its input.
    initial begin
        int unsigned gap;
        int unsigned take_run;
        logic        take_calm;
        logic        squeezed;
        take_run  = 0;
        take_calm = 1'b0;
        squeezed  = 1'b0;
        out_stall = 1'b0;
        forever begin
            gap = draw_wait(take_run, take_calm);
            if (squeeze_due && !squeezed) begin
                gap      = LONG_HOLD;
                squeezed = 1'b1;
            end
            @(negedge clk);
            if (gap != 0) begin
                out_stall <= 1'b1;
                repeat (gap) @(negedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    // Watchdog: ends the run when no channel moves for too long.
    initial begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_req      = '0;
        cfg_valid   = 1'b0;
        cfg_data    = 1'b0;
        squeeze_due = 1'b0;
        clock_now   = 32'd0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_report(1'b1);

        // Directed part. Arm a type, then try to re-arm it without and with
        // overwrite.
        offer(set_req(8'h05, 32'd10, 1'b0));
        offer(set_req(8'hff, 32'hffff_ffff, 1'b0));
        offer(set_req(8'h05, 32'd3, 1'b0));
        offer(set_req(8'h05, 32'd3, 1'b1));
        // Ticks that come too soon: one and zero milliseconds elapsed.
        offer(tick_req(32'd1));
        offer(tick_req(32'd0));
        // Slot 0 runs out; it keeps its type afterwards.
        offer(tick_req(32'd4));
        // The empty code armed with overwrite counts down while still empty
        // and is reported with the empty code.
        offer(set_req(EMPTY_CODE_DEF, 32'd5, 1'b1));
        offer(set_req(8'h05, 32'd0, 1'b0));
        offer(tick_req(32'd10));
        // Fill the table, then ask for one more slot.
        for (int k = 8'h11; k <= 8'h17; k++) begin
            offer(set_req(8'(k), 32'd20, 1'b0));
            armed_codes.push_back(8'(k));
        end
        armed_codes.push_back(8'hff);
        offer(set_req(8'h20, 32'd7, 1'b0));
        // Every slot expires in one tick, then a tick that wraps the clock
        // with nothing left to expire.
        offer(set_req(8'hff, 32'd5, 1'b1));
        offer(tick_req(32'hffff_fff0));
        offer(tick_req(32'h0000_0010));
        clock_now = 32'h0000_0010;
        // Cancel a type that still holds an expired slot, and a type that holds no slot.
        offer(set_req(8'h11, 32'd0, 1'b0));
        offer(set_req(8'h99, 32'd0, 1'b1));

        // Random phases, each with its own reporting setting.
        for (int p = 0; p < PHASES; p++) begin
            write_report(PHASE_REPORT[p]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 2 && n == 40) begin
                    squeeze_due = 1'b1;
                end
                offer(random_req());
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (outstanding != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
